// ===== src/paft_pkg.sv =====
// Shared types, constants and helpers for the polygon affine transform block.
// Used by polygon_affine_transform and paft_divider; depends on nothing.
package paft_pkg;

  localparam int COORD_W       = 24;
  localparam int COEF_W        = 16;
  localparam int IDX_W         = 6;
  localparam int CNT_W         = 7;
  localparam int SCR_W         = 12;
  localparam int MODE_W        = 4;
  localparam int CFG_IDX_W     = 1;
  localparam int MAX_VERTS_DEF = 64;
  localparam int RESET_WIDTH   = 640;
  localparam int RESET_HEIGHT  = 480;

  // Multiplier operands, product, accumulator and divisor widths.
  localparam int MA_W  = COORD_W + 1;
  localparam int MB_W  = COEF_W + 1;
  localparam int P_W   = MA_W + MB_W;
  localparam int ACC_W = 60;
  localparam int K_W   = 32;
  localparam int DEN_W = K_W + 1;

  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t v;
    logic   sat;
  } clip_t;

  localparam logic [MODE_W-1:0] MODE_CLEAR     = 4'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD      = 4'd1;
  localparam logic [MODE_W-1:0] MODE_TRANSLATE = 4'd2;
  localparam logic [MODE_W-1:0] MODE_ROTATE    = 4'd3;
  localparam logic [MODE_W-1:0] MODE_MIRROR_Y  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_MIRROR_X  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_MIRROR_XY = 4'd6;
  localparam logic [MODE_W-1:0] MODE_SHEAR     = 4'd7;
  localparam logic [MODE_W-1:0] MODE_SCALE     = 4'd8;
  localparam logic [MODE_W-1:0] MODE_REFLECT   = 4'd9;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  localparam acc_t COORD_MAX  = acc_t'(8388607);
  localparam acc_t COORD_MIN  = acc_t'(-8388608);
  localparam acc_t ROUND_HALF = acc_t'(2048);
  localparam logic [K_W-1:0] ONE_SQ = K_W'(1 << 24);

  function automatic acc_t sx(input logic [COORD_W-1:0] v);
    sx = {{(ACC_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic clip_t clip24(input acc_t v);
    clip_t r;
    r.sat = 1'b0;
    r.v   = v[COORD_W-1:0];
    if (v > COORD_MAX) begin
      r.sat = 1'b1;
      r.v   = COORD_MAX[COORD_W-1:0];
    end else if (v < COORD_MIN) begin
      r.sat = 1'b1;
      r.v   = COORD_MIN[COORD_W-1:0];
    end
    clip24 = r;
  endfunction

endpackage

// ===== src/polygon_affine_transform.sv =====
// Polygon vertex store with translate, rotate, shear, scale, mirror and line reflection.
// Clear, load and rejected load leave the block idle; a load result strobes the next cycle.
// A transform first reads vertex 0 for the pivot (reflection also forms k and d), then
// handles one vertex at a time; rotate, shear, scale and reflection use the shared 25x17
// multiplier, and reflection runs two 60-step divisions on the serial divider.
// busy is high for the whole run; results cannot be stalled. Reset sets the screen to 640x480
// and empties the store; vertex memory contents are not cleared.
module polygon_affine_transform import paft_pkg::*; #(
  parameter int MAX_VERTS = MAX_VERTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [MODE_W-1:0]    mode_i,
  input  logic signed [23:0]   x_in_i,
  input  logic signed [23:0]   y_in_i,
  input  logic signed [15:0]   coef_a_i,
  input  logic signed [15:0]   coef_b_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SCR_W-1:0]     cfg_data_i,
  output logic                 result_valid_o,
  output logic [IDX_W-1:0]     vertex_index_o,
  output logic signed [23:0]   x_out_o,
  output logic signed [23:0]   y_out_o,
  output logic                 last_o,
  output logic                 store_full_o,
  output logic                 saturated_o
);

  localparam int AW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_PRD, S_PIV, S_PRE0, S_PRE1, S_RD, S_LD, S_MUL,
    S_FIN, S_DXS, S_DXW, S_DYS, S_DYW, S_EMIT
  } state_e;

  state_e              state_q;
  logic [SCR_W-1:0]    width_q, height_q;
  logic [CNT_W-1:0]    count_q;
  logic [IDX_W-1:0]    idx_q;
  logic [MODE_W-1:0]   mode_q;
  coord_t              xi_q, yi_q, cx_q, cy_q, x_q, y_q;
  logic signed [15:0]  a_q, b_q;
  logic signed [MA_W-1:0] dx_q, dy_q, ymc_q;
  logic [K_W-1:0]      k_q, d_q;
  logic [2:0]          step_q, pterm_q, kmax;
  logic                pv_q;
  logic signed [P_W-1:0] prod_q, mul_p;
  acc_t                accx_q, accy_q, resx_q, resy_q;

  logic                valid_q, last_q, full_q, sat_q;
  logic [IDX_W-1:0]    vidx_q;
  coord_t              xo_q, yo_q;

  // Vertex memory.
  coord_t              mem_x [MAX_VERTS];
  coord_t              mem_y [MAX_VERTS];
  coord_t              rd_x_q, rd_y_q;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  coord_t              mem_wx, mem_wy;

  // Shared multiplier.
  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;

  // Accumulate term control.
  logic                t_y, t_neg;
  logic [1:0]          t_sh;
  acc_t                sp, acc_sum;

  logic                div_start, div_done;
  acc_t                div_num, div_quo;
  acc_t                fin_x, fin_y;
  clip_t               cl_x, cl_y;
  logic                accept, room, is_last;

  assign accept  = start && (state_q == S_IDLE);
  assign room    = (count_q < CNT_W'(MAX_VERTS));
  assign is_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

  assign mem_we = (accept && mode_i == MODE_LOAD && room) || (state_q == S_EMIT);
  assign mem_wa = (state_q == S_EMIT) ? idx_q[AW-1:0] : count_q[AW-1:0];
  assign mem_wx = (state_q == S_EMIT) ? cl_x.v : x_in_i;
  assign mem_wy = (state_q == S_EMIT) ? cl_y.v : y_in_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_x[mem_wa] <= mem_wx;
      mem_y[mem_wa] <= mem_wy;
    end
    rd_x_q <= mem_x[idx_q[AW-1:0]];
    rd_y_q <= mem_y[idx_q[AW-1:0]];
  end

  always_comb begin
    ma = '0;
    mb = '0;
    if (state_q == S_PRE0) begin
      ma = MA_W'(a_q);
      mb = MB_W'(a_q);
    end else begin
      case (mode_q)
        MODE_ROTATE: begin
          ma = step_q[0] ? dy_q : dx_q;
          mb = (step_q == 3'd1 || step_q == 3'd2) ? MB_W'(b_q) : MB_W'(a_q);
        end
        MODE_SHEAR: begin
          ma = dy_q;
          mb = MB_W'(a_q);
        end
        MODE_SCALE: begin
          ma = step_q[0] ? dy_q : dx_q;
          mb = step_q[0] ? MB_W'(b_q) : MB_W'(a_q);
        end
        MODE_REFLECT: begin
          case (step_q)
            3'd0: begin ma = MA_W'(x_q); mb = {1'b0, k_q[15:0]}; end
            3'd1: begin ma = MA_W'(x_q); mb = {k_q[K_W-1], k_q[K_W-1:16]}; end
            3'd2: begin ma = ymc_q;      mb = MB_W'(a_q); end
            3'd3: begin ma = MA_W'(x_q); mb = MB_W'(a_q); end
            3'd4: begin ma = MA_W'(y_q); mb = {1'b0, k_q[15:0]}; end
            default: begin ma = MA_W'(y_q); mb = {k_q[K_W-1], k_q[K_W-1:16]}; end
          endcase
        end
        default: begin
          ma = '0;
          mb = '0;
        end
      endcase
    end
  end

  assign mul_p = ma * mb;

  always_comb begin
    case (mode_q)
      MODE_ROTATE:  kmax = 3'd4;
      MODE_SHEAR:   kmax = 3'd1;
      MODE_SCALE:   kmax = 3'd2;
      MODE_REFLECT: kmax = 3'd6;
      default:      kmax = 3'd0;
    endcase
  end

  // Which accumulator a product goes to, its sign and its weight.
  always_comb begin
    t_y   = 1'b0;
    t_neg = 1'b0;
    t_sh  = 2'd0;
    case (mode_q)
      MODE_ROTATE: begin
        t_y   = pterm_q[1];
        t_neg = (pterm_q == 3'd1);
      end
      MODE_SCALE: t_y = pterm_q[0];
      MODE_REFLECT: begin
        t_y   = (pterm_q >= 3'd3);
        t_neg = (pterm_q >= 3'd4);
        case (pterm_q)
          3'd1, 3'd5: t_sh = 2'd2;
          3'd2, 3'd3: t_sh = 2'd1;
          default:    t_sh = 2'd0;
        endcase
      end
      default: begin
        t_y   = 1'b0;
        t_neg = 1'b0;
        t_sh  = 2'd0;
      end
    endcase
  end

  always_comb begin
    acc_t base;
    base = {{(ACC_W-P_W){prod_q[P_W-1]}}, prod_q};
    case (t_sh)
      2'd1:    sp = base <<< 13;
      2'd2:    sp = base <<< 16;
      default: sp = base;
    endcase
    acc_sum = (t_y ? accy_q : accx_q) + (t_neg ? -sp : sp);
  end

  always_comb begin
    acc_t rx, ry, w8, h8;
    rx = (accx_q + ROUND_HALF) >>> 12;
    ry = (accy_q + ROUND_HALF) >>> 12;
    w8 = acc_t'({width_q, 8'd0});
    h8 = acc_t'({height_q, 8'd0});
    fin_x = sx(x_q);
    fin_y = sx(y_q);
    case (mode_q)
      MODE_TRANSLATE: begin
        fin_x = sx(x_q) + sx(xi_q);
        fin_y = sx(y_q) + sx(yi_q);
      end
      MODE_ROTATE, MODE_SCALE: begin
        fin_x = sx(cx_q) + rx;
        fin_y = sx(cy_q) + ry;
      end
      MODE_MIRROR_Y:  fin_x = w8 - sx(x_q);
      MODE_MIRROR_X:  fin_y = h8 - sx(y_q);
      MODE_MIRROR_XY: begin
        fin_x = w8 - sx(x_q);
        fin_y = h8 - sx(y_q);
      end
      MODE_SHEAR: fin_x = sx(x_q) + rx;
      default: begin
        fin_x = sx(x_q);
        fin_y = sx(y_q);
      end
    endcase
  end

  assign cl_x = clip24(resx_q);
  assign cl_y = clip24(resy_q);

  // Reflection rounds as floor((2N + D) / 2D).
  assign div_start = (state_q == S_DXS) || (state_q == S_DYS);
  assign div_num   = (((state_q == S_DXS) ? accx_q : accy_q) <<< 1) + acc_t'(d_q);

  paft_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   ({d_q, 1'b0}),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      width_q  <= SCR_W'(RESET_WIDTH);
      height_q <= SCR_W'(RESET_HEIGHT);
      count_q  <= '0;
      idx_q    <= '0;
      mode_q   <= MODE_CLEAR;
      xi_q     <= '0;
      yi_q     <= '0;
      a_q      <= '0;
      b_q      <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      x_q      <= '0;
      y_q      <= '0;
      dx_q     <= '0;
      dy_q     <= '0;
      ymc_q    <= '0;
      k_q      <= '0;
      d_q      <= '0;
      step_q   <= '0;
      pterm_q  <= '0;
      pv_q     <= 1'b0;
      prod_q   <= '0;
      accx_q   <= '0;
      accy_q   <= '0;
      resx_q   <= '0;
      resy_q   <= '0;
      valid_q  <= 1'b0;
      vidx_q   <= '0;
      xo_q     <= '0;
      yo_q     <= '0;
      last_q   <= 1'b0;
      full_q   <= 1'b0;
      sat_q    <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIDTH:  width_q  <= cfg_data_i;
          CFG_HEIGHT: height_q <= cfg_data_i;
          default:    ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (start) begin
            mode_q <= mode_i;
            xi_q   <= x_in_i;
            yi_q   <= y_in_i;
            a_q    <= coef_a_i;
            b_q    <= coef_b_i;
            case (mode_i) inside
              MODE_CLEAR: count_q <= '0;
              MODE_LOAD: begin
                valid_q <= 1'b1;
                last_q  <= 1'b1;
                sat_q   <= 1'b0;
                if (room) begin
                  vidx_q  <= count_q[IDX_W-1:0];
                  xo_q    <= x_in_i;
                  yo_q    <= y_in_i;
                  full_q  <= 1'b0;
                  count_q <= count_q + CNT_W'(1);
                end else begin
                  vidx_q <= '0;
                  xo_q   <= '0;
                  yo_q   <= '0;
                  full_q <= 1'b1;
                end
              end
              [MODE_TRANSLATE:MODE_REFLECT]: begin
                if (count_q != '0) begin
                  idx_q   <= '0;
                  state_q <= S_PRD;
                end
              end
              default: ;
            endcase
          end
        end
        S_PRD: state_q <= S_PIV;
        S_PIV: begin
          // Pivot is vertex 0 truncated toward zero to a whole pixel.
          cx_q <= {rd_x_q[23:8] + 16'(rd_x_q[23] && (rd_x_q[7:0] != 8'd0)), 8'd0};
          cy_q <= {rd_y_q[23:8] + 16'(rd_y_q[23] && (rd_y_q[7:0] != 8'd0)), 8'd0};
          state_q <= (mode_q == MODE_REFLECT) ? S_PRE0 : S_RD;
        end
        S_PRE0: begin
          prod_q  <= mul_p;
          state_q <= S_PRE1;
        end
        S_PRE1: begin
          k_q     <= ONE_SQ - prod_q[K_W-1:0];
          d_q     <= ONE_SQ + prod_q[K_W-1:0];
          state_q <= S_RD;
        end
        S_RD: state_q <= S_LD;
        S_LD: begin
          x_q    <= rd_x_q;
          y_q    <= rd_y_q;
          dx_q   <= MA_W'(rd_x_q) - MA_W'(cx_q);
          dy_q   <= MA_W'(rd_y_q) - MA_W'(cy_q);
          ymc_q  <= MA_W'(rd_y_q) - MA_W'(yi_q);
          accx_q <= '0;
          accy_q <= (mode_q == MODE_REFLECT) ? (sx(yi_q) <<< 25) : '0;
          step_q <= '0;
          pv_q   <= 1'b0;
          case (mode_q)
            MODE_ROTATE, MODE_SHEAR, MODE_SCALE, MODE_REFLECT: state_q <= S_MUL;
            default: state_q <= S_FIN;
          endcase
        end
        S_MUL: begin
          // Product of step s is added while step s+1 is multiplied.
          if (pv_q) begin
            if (t_y) accy_q <= acc_sum;
            else     accx_q <= acc_sum;
          end
          prod_q  <= mul_p;
          pterm_q <= step_q;
          pv_q    <= (step_q != kmax);
          if (step_q == kmax) begin
            state_q <= (mode_q == MODE_REFLECT) ? S_DXS : S_FIN;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        S_FIN: begin
          resx_q  <= fin_x;
          resy_q  <= fin_y;
          state_q <= S_EMIT;
        end
        S_DXS: state_q <= S_DXW;
        S_DXW: begin
          if (div_done) begin
            resx_q  <= div_quo;
            state_q <= S_DYS;
          end
        end
        S_DYS: state_q <= S_DYW;
        S_DYW: begin
          if (div_done) begin
            resy_q  <= div_quo;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          valid_q <= 1'b1;
          vidx_q  <= idx_q;
          xo_q    <= cl_x.v;
          yo_q    <= cl_y.v;
          last_q  <= is_last;
          full_q  <= 1'b0;
          sat_q   <= cl_x.sat || cl_y.sat;
          if (is_last) begin
            state_q <= S_IDLE;
          end else begin
            idx_q   <= idx_q + IDX_W'(1);
            state_q <= S_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign vertex_index_o = vidx_q;
  assign x_out_o        = xo_q;
  assign y_out_o        = yo_q;
  assign last_o         = last_q;
  assign store_full_o   = full_q;
  assign saturated_o    = sat_q;

  a_full_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && store_full_o) |->
      (last_o && !saturated_o && vertex_index_o == '0 && x_out_o == '0))
    else $error("rejected load result has wrong fields");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_VERTS))
    else $error("vertex count exceeds store depth");

  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i == MODE_LOAD && room) |=>
      (result_valid_o && !store_full_o && last_o))
    else $error("accepted load gave no result");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy)
    else $error("block idle in the middle of a transform run");

endmodule

// ===== src/paft_divider.sv =====
// Restoring radix-2 divider giving the floor of a signed dividend by a positive divisor.
// One quotient bit per cycle; depends on paft_pkg.
module paft_divider import paft_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  acc_t             num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output acc_t             quo_o
);

  localparam int CW = $clog2(ACC_W + 1);

  logic             busy_q, done_q, neg_q;
  logic [CW-1:0]    cnt_q;
  logic [DEN_W-1:0] den_q, rem_q, rem_d;
  logic [ACC_W-1:0] q_q;
  logic [DEN_W:0]   trial;
  logic             ge;
  acc_t             quo_q;

  assign trial = {rem_q, q_q[ACC_W-1]};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    logic [DEN_W:0] diff;
    diff  = trial - {1'b0, den_q};
    rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      q_q    <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        neg_q  <= num_i[ACC_W-1];
        q_q    <= num_i[ACC_W-1] ? -num_i : num_i;
        rem_q  <= '0;
        den_q  <= den_i;
        cnt_q  <= CW'(ACC_W);
      end else if (busy_q) begin
        if (cnt_q != '0) begin
          rem_q <= rem_d;
          q_q   <= {q_q[ACC_W-2:0], ge};
          cnt_q <= cnt_q - CW'(1);
        end else begin
          // A negative dividend with a remainder rounds one further down.
          quo_q  <= neg_q ? (-$signed(q_q) - acc_t'(rem_q != '0)) : $signed(q_q);
          done_q <= 1'b1;
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for polygon_affine_transform: directed and random transactions.
// Depends on paft_pkg and the polygon_affine_transform RTL; it predicts every vertex result.
module tb_top import paft_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 4'd10;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 4'd15;
  localparam int  VERT_MAX   = 64;
  localparam int  CYCLE_CAP  = 20000000;
  localparam longint C_MAX   = 64'sd8388607;
  localparam longint C_MIN   = -64'sd8388608;
  localparam longint Q12     = 64'sd4096;

  typedef struct {
    logic [IDX_W-1:0]   idx;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic               last;
    logic               full;
    logic               sat;
  } vertex_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [MODE_W-1:0] mode_i = MODE_CLEAR;
  logic signed [23:0] x_in_i = '0;
  logic signed [23:0] y_in_i = '0;
  logic signed [15:0] coef_a_i = '0;
  logic signed [15:0] coef_b_i = '0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_WIDTH;
  logic [SCR_W-1:0] cfg_data_i = '0;
  logic result_valid_o;
  logic [IDX_W-1:0] vertex_index_o;
  logic signed [23:0] x_out_o;
  logic signed [23:0] y_out_o;
  logic last_o, store_full_o, saturated_o;

  polygon_affine_transform u_dut (.*);

  always #2 clk_i = ~clk_i;

  // Predictor state.
  longint poly_x[VERT_MAX];
  longint poly_y[VERT_MAX];
  int     poly_count;
  longint scr_w, scr_h;
  vertex_res_t pending_vertices[$];

  int errors, checked, n_items, n_sat, n_full;
  int gap_pct;
  longint cycles = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result checker: the receiver never stalls, so every strobe is one vertex result.
  always @(posedge clk_i) begin
    vertex_res_t e;
    if (rst_ni && result_valid_o) begin
      if (pending_vertices.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected result idx=%0d x=%0d y=%0d", vertex_index_o, x_out_o, y_out_o);
      end else begin
        e = pending_vertices.pop_front();
        checked++;
        if (e.idx !== vertex_index_o || e.x !== x_out_o || e.y !== y_out_o ||
            e.last !== last_o || e.full !== store_full_o || e.sat !== saturated_o) begin
          errors++;
          if (errors <= 10) begin
            $display("Mismatch: exp idx=%0d x=%0d y=%0d last=%b full=%b sat=%b",
                     e.idx, e.x, e.y, e.last, e.full, e.sat);
            $display("          got idx=%0d x=%0d y=%0d last=%b full=%b sat=%b",
                     vertex_index_o, x_out_o, y_out_o, last_o, store_full_o, saturated_o);
          end
        end
      end
    end
  end

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q -= 1;
    return q;
  endfunction

  function automatic longint round_div(longint n, longint d);
    return floor_div(2 * n + d, 2 * d);
  endfunction

  function automatic longint clamp24(longint v, inout logic sat);
    if (v > C_MAX) begin
      sat = 1'b1;
      return C_MAX;
    end
    if (v < C_MIN) begin
      sat = 1'b1;
      return C_MIN;
    end
    return v;
  endfunction

  // Appends one expected result at the tail of the queue.
  task automatic queue_expected(vertex_res_t r);
    pending_vertices.insert(pending_vertices.size(), r);
  endtask

  // Applies one transaction to the predicted polygon and queues the vertices it reports.
  task automatic predict_polygon(logic [MODE_W-1:0] m, longint xi, longint yi,
                                 longint a, longint b);
    vertex_res_t r;
    longint cx, cy, x, y, dx, dy, nx, ny, one2, a2;
    logic sat;
    if (m == MODE_CLEAR) begin
      poly_count = 0;
    end else if (m == MODE_LOAD) begin
      r.last = 1'b1;
      r.sat = 1'b0;
      if (poly_count >= VERT_MAX) begin
        r.idx = '0; r.x = '0; r.y = '0; r.full = 1'b1;
        n_full++;
      end else begin
        poly_x[poly_count] = xi;
        poly_y[poly_count] = yi;
        r.idx = IDX_W'(poly_count); r.x = 24'(xi); r.y = 24'(yi); r.full = 1'b0;
        poly_count++;
      end
      queue_expected(r);
    end else if (m <= MODE_REFLECT && poly_count > 0) begin
      cx = (poly_x[0] / 256) * 256;
      cy = (poly_y[0] / 256) * 256;
      one2 = Q12 * Q12;
      a2 = a * a;
      for (int i = 0; i < poly_count; i++) begin
        x = poly_x[i]; y = poly_y[i];
        dx = x - cx; dy = y - cy;
        nx = x; ny = y;
        sat = 1'b0;
        case (m)
          MODE_TRANSLATE: begin
            nx = x + xi; ny = y + yi;
          end
          MODE_ROTATE: begin
            nx = cx + round_div(dx * a - dy * b, Q12);
            ny = cy + round_div(dx * b + dy * a, Q12);
          end
          MODE_MIRROR_Y: nx = scr_w * 256 - x;
          MODE_MIRROR_X: ny = scr_h * 256 - y;
          MODE_MIRROR_XY: begin
            nx = scr_w * 256 - x; ny = scr_h * 256 - y;
          end
          MODE_SHEAR: nx = x + round_div(a * dy, Q12);
          MODE_SCALE: begin
            nx = cx + round_div(dx * a, Q12);
            ny = cy + round_div(dy * b, Q12);
          end
          default: begin
            nx = round_div((one2 - a2) * x + 2 * Q12 * a * (y - yi), one2 + a2);
            ny = round_div(2 * Q12 * a * x + (a2 - one2) * y + 2 * one2 * yi, one2 + a2);
          end
        endcase
        nx = clamp24(nx, sat);
        ny = clamp24(ny, sat);
        poly_x[i] = nx; poly_y[i] = ny;
        r.idx = IDX_W'(i); r.x = 24'(nx); r.y = 24'(ny);
        r.last = (i + 1 == poly_count); r.full = 1'b0; r.sat = sat;
        if (sat) n_sat++;
        queue_expected(r);
      end
    end
  endtask

  // Sends one transaction; called and returning at a falling edge.
  task automatic send_item(logic [MODE_W-1:0] m, longint xi, longint yi,
                           longint a, longint b);
    while ($urandom_range(99) < gap_pct) @(negedge clk_i);
    mode_i = m; x_in_i = 24'(xi); y_in_i = 24'(yi);
    coef_a_i = 16'(a); coef_b_i = 16'(b);
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    predict_polygon(m, longint'(x_in_i), longint'(y_in_i),
                    longint'(coef_a_i), longint'(coef_b_i));
    n_items++;
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic wait_idle();
    repeat (2) @(posedge clk_i);
    while (pending_vertices.size() != 0 || busy) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_screen(logic [CFG_IDX_W-1:0] idx, int value);
    wait_idle();
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = SCR_W'(value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_WIDTH) scr_w = value; else scr_h = value;
  endtask

  function automatic longint rand_coord();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return longint'($urandom_range(102400)) - 51200;
    if (pick < 90) return longint'(24'($urandom));
    return (pick < 95) ? C_MAX : C_MIN;
  endfunction

  function automatic longint rand_coef();
    int pick;
    pick = $urandom_range(99);
    if (pick < 75) return longint'($urandom_range(16384)) - 8192;
    if (pick < 92) return longint'(16'($urandom));
    return (pick < 96) ? 32767 : -32768;
  endfunction

  task automatic test_directed_modes();
    send_item(MODE_TRANSLATE, 256, 256, 0, 0);   // empty store, no result
    send_item(MODE_UNUSED_LO, 1, 1, 1, 1);
    send_item(MODE_LOAD, C_MAX, C_MIN, 0, 0);
    send_item(MODE_LOAD, -1, 8388351, 0, 0);
    send_item(MODE_LOAD, 1000, -767, 0, 0);
    send_item(MODE_TRANSLATE, C_MAX, C_MIN, 0, 0);
    send_item(MODE_ROTATE, 0, 0, 4096, 0);
    send_item(MODE_ROTATE, 0, 0, -32768, 32767);
    send_item(MODE_MIRROR_Y, 0, 0, 0, 0);
    send_item(MODE_MIRROR_X, 0, 0, 0, 0);
    send_item(MODE_MIRROR_XY, 0, 0, 0, 0);
    send_item(MODE_SHEAR, 0, 0, 32767, 0);
    send_item(MODE_SCALE, 0, 0, -32768, 32767);
    send_item(MODE_REFLECT, 0, 12800, -32768, 0);
    send_item(MODE_REFLECT, 0, C_MIN, 32767, 0);
    send_item(MODE_UNUSED_HI, -1, -1, -1, -1);
    send_item(MODE_CLEAR, 0, 0, 0, 0);
    send_item(MODE_SCALE, 0, 0, 4096, 4096);     // empty again
  endtask

  task automatic test_screen_extremes();
    write_screen(CFG_WIDTH, 0);
    write_screen(CFG_HEIGHT, 4095);
    send_item(MODE_LOAD, 2560, -2560, 0, 0);
    send_item(MODE_MIRROR_XY, 0, 0, 0, 0);
    write_screen(CFG_WIDTH, 4095);
    write_screen(CFG_HEIGHT, 0);
    send_item(MODE_MIRROR_XY, 0, 0, 0, 0);
    send_item(MODE_CLEAR, 0, 0, 0, 0);
  endtask

  task automatic test_store_full();
    for (int i = 0; i < VERT_MAX; i++) send_item(MODE_LOAD, rand_coord(), rand_coord(), 0, 0);
    send_item(MODE_LOAD, 77, 77, 0, 0);
    send_item(MODE_TRANSLATE, 512, -512, 0, 0);
    send_item(MODE_MIRROR_Y, 0, 0, 0, 0);
    send_item(MODE_CLEAR, 0, 0, 0, 0);
  endtask

  // Polygons of 1 to 6 vertices, now and then 20 to 40, then random transactions on each.
  task automatic test_random_polygons(int n_target);
    int stop_at, nv, nt;
    logic [MODE_W-1:0] m;
    stop_at = n_items + n_target;
    while (n_items < stop_at) begin
      if ($urandom_range(9) == 0) begin
        write_screen(CFG_WIDTH, $urandom_range(4095));
        write_screen(CFG_HEIGHT, $urandom_range(4095));
      end
      send_item(MODE_CLEAR, rand_coord(), rand_coord(), rand_coef(), rand_coef());
      nv = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      for (int i = 0; i < nv; i++)
        send_item(MODE_LOAD, rand_coord(), rand_coord(), rand_coef(), rand_coef());
      nt = $urandom_range(1, 6);
      for (int i = 0; i < nt; i++) begin
        if ($urandom_range(19) == 0) m = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
        else if ($urandom_range(19) == 0) m = MODE_LOAD;
        else m = MODE_W'($urandom_range(MODE_TRANSLATE, MODE_REFLECT));
        send_item(m, rand_coord(), rand_coord(), rand_coef(), rand_coef());
      end
    end
  endtask

  initial begin
    errors = 0; checked = 0; n_items = 0; n_sat = 0; n_full = 0;
    poly_count = 0; scr_w = RESET_WIDTH; scr_h = RESET_HEIGHT;
    gap_pct = 11;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed_modes();
    test_screen_extremes();
    test_store_full();
    write_screen(CFG_WIDTH, RESET_WIDTH);
    write_screen(CFG_HEIGHT, RESET_HEIGHT);
    gap_pct = 11;
    test_random_polygons(110);
    gap_pct = 88;
    test_random_polygons(110);
    gap_pct = 0;
    test_random_polygons(110);
    wait_idle();
    repeat (50) @(posedge clk_i);
    $display("Sent %0d transactions and checked %0d vertex results", n_items, checked);
    $display("%0d saturated vertices, %0d rejected loads, %0d errors", n_sat, n_full, errors);
    if (errors == 0 && pending_vertices.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== polygon_affine_transform.f =====
src/paft_pkg.sv
src/paft_divider.sv
src/polygon_affine_transform.sv
dv/tb_top.sv
